// ----- rtl/pbc_pkg.sv -----
package pbc_pkg;

  // default log2 of the guess table depth
  localparam int TABLE_BITS_DEF = 20;

  // shift applied to the context hash before the byte is added
  localparam int HASH_SHIFT = 5;

  // byte width of the stream
  localparam int BYTE_BITS = 8;

  // operating mode register codes
  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

endpackage

// ----- rtl/pbc_ram.sv -----
module pbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/predictor_byte_codec.sv -----
// Path: an accepted byte is registered in the table stage, then in the output register,
// from which it transfers out.
// Throughput: one byte per cycle while the output is not stalled and no clearing pass runs; the loop
// from guess table read data through the hash update back to the table read address sets this rate.
// Reset (rst, synchronous): clears mode, context hash and pipeline, then runs a clearing
// pass over all 2**TABLE_BITS guess table entries with in_stall held high.
module predictor_byte_codec
  import pbc_pkg::*;
#(
  parameter int TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // mode register write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  // input byte stream
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       hit_flag,
  // result stream
  output logic       out_valid,
  input  logic       out_stall,
  output logic       hit,
  output logic [7:0] byte_out
);

  localparam int TableDepth = 2 ** TABLE_BITS;

  mode_t                  mode;
  logic                   clearing;
  logic [TABLE_BITS-1:0]  clear_addr;
  logic [TABLE_BITS-1:0]  hash_reg;
  logic [TABLE_BITS-1:0]  hash_cur;
  logic [TABLE_BITS-1:0]  hash_calc;

  logic                   s1_valid;
  logic [TABLE_BITS-1:0]  s1_slot;
  logic [BYTE_BITS-1:0]   s1_data;
  logic                   s1_flag;
  logic                   s1_go;
  logic                   s1_write;
  logic                   s1_hit;
  logic [BYTE_BITS-1:0]   s1_byte;
  logic [BYTE_BITS-1:0]   guess;

  logic                   fwd_hit;
  logic [BYTE_BITS-1:0]   fwd_data;

  logic                   in_accept;
  logic                   ram_wr_en;
  logic [TABLE_BITS-1:0]  ram_wr_addr;
  logic [BYTE_BITS-1:0]   ram_wr_data;
  logic [BYTE_BITS-1:0]   ram_rd_data;

  // mode register; the user must write it only while idle, the block itself does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ENCODE;
    end else if (cfg_valid && cfg_ready) begin
      mode <= mode_t'(cfg_data);
    end
  end

  // handshake control
  assign s1_go     = !out_valid || !out_stall;
  assign in_stall  = clearing || (s1_valid && !s1_go);
  assign in_accept = in_valid && !in_stall;
  assign s1_write  = s1_valid && s1_go && !s1_hit;

  // guess with forwarding of the write that landed on the read edge
  assign guess = fwd_hit ? fwd_data : ram_rd_data;

  // encode/decode decision for the item in the table stage
  always_comb begin
    case (mode)
      MODE_ENCODE: begin
        s1_byte = s1_data;
        s1_hit  = (guess == s1_data);
      end
      MODE_DECODE: begin
        s1_byte = s1_flag ? guess : s1_data;
        s1_hit  = s1_flag;
      end
      default: begin
        s1_byte = s1_data;
        s1_hit  = 1'b0;
      end
    endcase
  end

  // context hash for the next item
  assign hash_calc = (s1_slot << HASH_SHIFT)
                   + {{(TABLE_BITS-BYTE_BITS){1'b0}}, s1_byte};
  assign hash_cur  = s1_valid ? hash_calc : hash_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_reg <= '0;
    end else if (s1_valid && s1_go) begin
      hash_reg <= hash_calc;
    end
  end

  // table stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_slot <= hash_cur;
      s1_data <= data_byte;
      s1_flag <= hit_flag;
    end
  end

  // same-entry write and read on one edge: keep the written byte
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (in_accept) begin
      fwd_hit <= s1_write && (s1_slot == hash_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      fwd_data <= s1_byte;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == {TABLE_BITS{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  // table write port
  assign ram_wr_en   = clearing || s1_write;
  assign ram_wr_addr = clearing ? clear_addr : s1_slot;
  assign ram_wr_data = clearing ? '0 : s1_byte;

  pbc_ram #(
    .WIDTH (BYTE_BITS),
    .DEPTH (TableDepth)
  ) u_guess_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (in_accept),
    .rd_addr (hash_cur),
    .rd_data (ram_rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_go) begin
      hit      <= s1_hit;
      byte_out <= s1_byte;
    end
  end

  // no transfer accepted during the clearing pass
  assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_accept)
    else $error("input transfer during table clearing");

  // the table stage is empty while clearing
  assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid)
    else $error("table stage busy during clearing");

  // a held table stage keeps its slot
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_slot)))
    else $error("table stage lost its item while stalled");

  // forwarding only follows a table write on the read edge
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && !(s1_valid && s1_go && !s1_hit)) |=> !fwd_hit)
    else $error("forward flag set without a table write");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import pbc_pkg::*;

  localparam int TBITS        = TABLE_BITS_DEF;
  // clearing pass over all 2**20 table entries plus a slow stream, taken several times over
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int PHASE_ITEMS  = 260;
  localparam int PHASE_COUNT  = 6;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 80;
  localparam int ROW_COUNT    = 22;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } result_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] data;
    logic       flag;
    logic       typed;
    logic       hit;
    logic [7:0] value;
  } stim_row_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data  = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       hit_flag  = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       hit;
  logic [7:0] byte_out;

  // predictor state: guess per context, running context hash, mode copy
  bit   [7:0]       guess_mem [0:(1 << TBITS) - 1];
  logic [TBITS-1:0] context_q = '0;
  mode_t            cur_mode  = MODE_ENCODE;

  result_t pending_results [$];
  int      errors        = 0;
  int      results_seen  = 0;
  int      burst_left    = 0;
  int      cycle_count   = 0;

  // directed rows: typed expectations only where they follow at a glance
  stim_row_t directed_rows [ROW_COUNT] = '{
    // from reset: table zero, hash zero, encode
    '{MODE_ENCODE, 8'h00, 1'b0, 1'b1, 1'b1, 8'h00},
    '{MODE_ENCODE, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00},  // flag ignored
    '{MODE_ENCODE, 8'hFF, 1'b1, 1'b1, 1'b0, 8'hFF},  // miss, slot 0 gets ff
    '{MODE_ENCODE, 8'hFF, 1'b0, 1'b1, 1'b0, 8'hFF},
    // four zero bytes bring the hash back to zero
    '{MODE_ENCODE, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{MODE_ENCODE, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
    '{MODE_ENCODE, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{MODE_ENCODE, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
    '{MODE_ENCODE, 8'hFF, 1'b0, 1'b1, 1'b1, 8'hFF},  // hit on stored literal
    '{MODE_ENCODE, 8'h80, 1'b0, 1'b1, 1'b0, 8'h80},
    '{MODE_ENCODE, 8'h01, 1'b1, 1'b0, 1'b0, 8'h00},
    '{MODE_ENCODE, 8'h7F, 1'b0, 1'b0, 1'b0, 8'h00},
    // switch to decode mid-stream, table and hash kept
    '{MODE_DECODE, 8'hA5, 1'b0, 1'b1, 1'b0, 8'hA5},
    '{MODE_DECODE, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
    '{MODE_DECODE, 8'hFF, 1'b1, 1'b0, 1'b0, 8'h00},  // literal ignored on hit
    '{MODE_DECODE, 8'h5A, 1'b0, 1'b1, 1'b0, 8'h5A},
    '{MODE_DECODE, 8'hFF, 1'b0, 1'b1, 1'b0, 8'hFF},
    '{MODE_DECODE, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00},
    '{MODE_DECODE, 8'h55, 1'b1, 1'b0, 1'b0, 8'h00},
    // and back to encode
    '{MODE_ENCODE, 8'hAA, 1'b1, 1'b0, 1'b0, 8'h00},
    '{MODE_ENCODE, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00},
    '{MODE_ENCODE, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00}
  };

  predictor_byte_codec uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .hit_flag  (hit_flag),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .byte_out  (byte_out)
  );

  always #5 clk = ~clk;

  // one byte through the codec: compare, update table on a literal, advance hash
  function automatic result_t predict_codec(input logic [7:0] d, input logic f);
    result_t    res;
    logic [7:0] guess;
    guess = guess_mem[context_q];
    if (cur_mode == MODE_ENCODE) begin
      res.value = d;
      res.hit   = (guess == d);
    end else if (f) begin
      res.value = guess;
      res.hit   = 1'b1;
    end else begin
      res.value = d;
      res.hit   = 1'b0;
    end
    if (!res.hit) guess_mem[context_q] = res.value;
    context_q = (context_q << HASH_SHIFT) + res.value;
    return res;
  endfunction

  function automatic logic [7:0] narrow_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h55;
      default: return 8'hAA;
    endcase
  endfunction

  // offer one byte in bursts with random gaps, record its expected result
  task automatic send_byte(input logic [7:0] d, input logic f, input logic typed,
                           input result_t typed_res);
    int      gap;
    result_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid  <= 1'b1;
    data_byte <= d;
    hit_flag  <= f;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predicted = predict_codec(d, f);
    pending_results.push_back(typed ? typed_res : predicted);
    burst_left--;
    @(negedge clk);
  endtask

  // stop offering and let every expected result come out
  task automatic drain_stream();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cur_mode = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // repeated phrases give hits; decode sends literals first, then hit flags
  task automatic run_random_phase(input int n_items);
    int         sent;
    int         kind;
    int         len;
    int         reps;
    int         r;
    int         i;
    logic       narrow;
    logic [7:0] phrase [12];
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        len    = $urandom_range(2, 12);
        reps   = $urandom_range(2, 6);
        narrow = 1'($urandom_range(0, 1));
        for (i = 0; i < len; i++)
          phrase[i] = narrow ? narrow_byte() : 8'($urandom_range(0, 255));
        for (r = 0; r < reps; r++) begin
          for (i = 0; i < len; i++) begin
            if (cur_mode == MODE_ENCODE)
              send_byte(phrase[i], 1'($urandom_range(0, 1)), 1'b0, '0);
            else if (r == 0 || $urandom_range(0, 7) == 0)
              send_byte(phrase[i], 1'b0, 1'b0, '0);
            else
              send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
            sent++;
          end
        end
      end else if (kind <= 7) begin
        len = $urandom_range(5, 20);
        for (i = 0; i < len; i++) begin
          send_byte(narrow_byte(), 1'($urandom_range(0, 1)), 1'b0, '0);
          sent++;
        end
      end else begin
        len = $urandom_range(1, 15);
        for (i = 0; i < len; i++) begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  // receiver stall patterns, with one long hold to back up the pipeline
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   pat_kind  = 0;
  int   pat_left  = 0;
  logic toggle    = 1'b0;

  always @(negedge clk) begin
    if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (pat_left == 0) begin
        pat_kind = $urandom_range(0, 3);
        pat_left = $urandom_range(20, 80);
      end
      pat_left--;
      toggle = ~toggle;
      case (pat_kind)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= toggle;
      endcase
    end
  end

  // result transfer check against the oldest expectation
  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got hit=%0d byte=%02h",
                 $time, hit, byte_out);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (hit !== exp_res.hit) begin
          $display("%0t: hit mismatch: expected %0d, got %0d", $time, exp_res.hit, hit);
          errors++;
        end
        if (byte_out !== exp_res.value) begin
          $display("%0t: byte_out mismatch: expected %02h, got %02h",
                   $time, exp_res.value, byte_out);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // main sequence: reset, directed rows, then alternating random phases
  initial begin
    int    k;
    mode_t next_mode;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    for (k = 0; k < ROW_COUNT; k++) begin
      if (directed_rows[k].mode != cur_mode) begin
        drain_stream();
        write_mode(directed_rows[k].mode);
      end
      send_byte(directed_rows[k].data, directed_rows[k].flag, directed_rows[k].typed,
                result_t'{directed_rows[k].hit, directed_rows[k].value});
    end
    for (k = 0; k < PHASE_COUNT; k++) begin
      drain_stream();
      next_mode = (cur_mode == MODE_ENCODE) ? MODE_DECODE : MODE_ENCODE;
      write_mode(next_mode);
      run_random_phase(PHASE_ITEMS);
    end
    drain_stream();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- predictor_byte_codec.f -----
rtl/pbc_pkg.sv
rtl/pbc_ram.sv
rtl/predictor_byte_codec.sv
tb/tb_top.sv
